[sv/cat_pkg.sv]
// Shared types, widths and the arctangent table for the CORDIC atan2 block.
// No dependencies; used by cat_cell and cordic_atan2_16.
package cat_pkg;

  localparam int ITERATIONS = 15;
  localparam int IDX_W      = 4;
  localparam int XY_W       = 19;
  localparam int ANG_W      = 16;
  localparam int COORD_W    = 16;

  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic [ANG_W-1:0]        ang_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic valid;
    logic xneg;
    logic yneg;
    xy_t  x;
    xy_t  y;
    ang_t acc;
  } cat_word_t;

  localparam ang_t HALF_TURN = ang_t'(16'h8000);

  // trunc(65536 * atan(2^-i) / pi)
  function automatic ang_t atan_lut(input idx_t i);
    ang_t r;
    unique case (i)
      4'd0:  r = ang_t'(16384);
      4'd1:  r = ang_t'(9672);
      4'd2:  r = ang_t'(5110);
      4'd3:  r = ang_t'(2594);
      4'd4:  r = ang_t'(1302);
      4'd5:  r = ang_t'(651);
      4'd6:  r = ang_t'(325);
      4'd7:  r = ang_t'(162);
      4'd8:  r = ang_t'(81);
      4'd9:  r = ang_t'(40);
      4'd10: r = ang_t'(20);
      4'd11: r = ang_t'(10);
      4'd12: r = ang_t'(5);
      4'd13: r = ang_t'(2);
      4'd14: r = ang_t'(1);
      4'd15: r = ang_t'(0);
    endcase
    return r;
  endfunction

endpackage

[sv/cordic_atan2_16.sv]
// Top level of the 16-bit CORDIC atan2: quadrant fold, chain of rotation cells,
// final angle fixup. Depends on cat_pkg and cat_cell.
//
// Usage:
//   Drive x_coord and y_coord and raise start; the word is taken at the rising
//   edge where start is high and busy is low. busy is high only while rst is
//   applied and the cycle after, so a new point may enter on every clock.
//   The angle appears on angle with done high for exactly one cycle, after
//   the edge that took the word: the fold into the first quadrant registers
//   at that edge, then each rotation cell registers in turn, then the final
//   halving, mirror and negation register the angle. Results leave in the
//   order points entered.
//   Throughput is one point per clock; the chain of cells sets the latency.
//   The receiver cannot stall: done is a strobe and the angle is gone the
//   next cycle. angle is 0x8000 for pi and wraps at two pi.
//   Reset clears every word in the chain, dropping words in flight;
//   no result is produced for them.
module cordic_atan2_16 (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cat_pkg::coord_t     x_coord,
  input  cat_pkg::coord_t     y_coord,
  output logic                done,
  output cat_pkg::ang_t       angle
);

  cat_pkg::cat_word_t chain [0:cat_pkg::ITERATIONS];
  cat_pkg::cat_word_t front_next;
  cat_pkg::xy_t       xs;
  cat_pkg::xy_t       ys;
  cat_pkg::ang_t      half;
  cat_pkg::ang_t      mirrored;
  cat_pkg::ang_t      angle_next;
  logic               in_busy;

  assign busy = in_busy;

  always_ff @(posedge clk) begin
    in_busy <= rst;
  end

  // fold into the first quadrant with widened magnitudes
  always_comb begin
    xs = cat_pkg::xy_t'(x_coord);
    ys = cat_pkg::xy_t'(y_coord);
    front_next.valid = start && !in_busy;
    front_next.xneg  = x_coord[cat_pkg::COORD_W-1];
    front_next.yneg  = y_coord[cat_pkg::COORD_W-1];
    front_next.x     = x_coord[cat_pkg::COORD_W-1] ? -xs : xs;
    front_next.y     = y_coord[cat_pkg::COORD_W-1] ? -ys : ys;
    front_next.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= front_next;
    end
  end

  for (genvar g = 0; g < cat_pkg::ITERATIONS; g++) begin : g_cell
    cat_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (cat_pkg::idx_t'(g)),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  always_comb begin
    half       = chain[cat_pkg::ITERATIONS].acc >> 1;
    mirrored   = chain[cat_pkg::ITERATIONS].xneg ? (cat_pkg::HALF_TURN - half) : half;
    angle_next = chain[cat_pkg::ITERATIONS].yneg ? (cat_pkg::ang_t'(0) - mirrored)
                                                 : mirrored;
  end

  always_ff @(posedge clk) begin
    angle <= angle_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[cat_pkg::ITERATIONS].valid;
    end
  end

endmodule

[sv/cat_cell.sv]
// One CORDIC vectoring rotation, registered; cells are chained in cordic_atan2_16.
// Depends on cat_pkg.
module cat_cell (
  input  logic               clk,
  input  logic               rst,
  input  cat_pkg::idx_t      idx,
  input  cat_pkg::cat_word_t word_in,
  output cat_pkg::cat_word_t word_out
);

  cat_pkg::cat_word_t word_next;
  cat_pkg::xy_t       xd;
  cat_pkg::xy_t       yd;
  cat_pkg::ang_t      step;

  always_comb begin
    xd        = word_in.x >>> idx;
    yd        = word_in.y >>> idx;
    step      = cat_pkg::atan_lut(idx);
    word_next = word_in;
    // hold the word unchanged once y has reached zero
    if (word_in.y != '0) begin
      if (!word_in.y[cat_pkg::XY_W-1]) begin
        word_next.x   = word_in.x + yd;
        word_next.y   = word_in.y - xd;
        word_next.acc = word_in.acc + step;
      end else begin
        word_next.x   = word_in.x - yd;
        word_next.y   = word_in.y + xd;
        word_next.acc = word_in.acc - step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out <= '0;
    end else begin
      word_out <= word_next;
    end
  end

endmodule

[tb/tb_cordic_atan2_16.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cordic_atan2_16: a directed table of points, then random points.
// Angles are checked vs typed values or a vectoring model. Depends on cat_pkg and the RTL.
module tb_cordic_atan2_16;
  import cat_pkg::*;

  localparam int N_RANDOM  = 1230;
  localparam int MAX_SHOWN = 10;

  // trunc(65536 * atan(2^-i) / pi), one entry per rotation
  localparam ang_t ARCTAN_STEP [16] = '{
    16'd16384, 16'd9672, 16'd5110, 16'd2594, 16'd1302, 16'd651, 16'd325, 16'd162,
    16'd81, 16'd40, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1, 16'd0
  };

  typedef struct {
    coord_t x;
    coord_t y;
    bit     typed;
    ang_t   angle;
  } point_row_t;

  localparam int N_ROWS = 22;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  coord_t x_coord = '0;
  coord_t y_coord = '0;
  logic   done;
  ang_t   angle;

  ang_t angle_q[$];
  int   bad_count = 0;
  bit   burst = 1'b0;

  point_row_t point_rows [N_ROWS] = '{
    '{coord_t'(0),      coord_t'(0),      1'b1, 16'h0000},
    '{coord_t'(1),      coord_t'(0),      1'b1, 16'h0000},
    '{coord_t'(32767),  coord_t'(0),      1'b1, 16'h0000},
    '{coord_t'(-1),     coord_t'(0),      1'b1, HALF_TURN},
    '{coord_t'(-32768), coord_t'(0),      1'b1, HALF_TURN},
    '{coord_t'(0),      coord_t'(1),      1'b0, 16'h0000},
    '{coord_t'(0),      coord_t'(-1),     1'b0, 16'h0000},
    '{coord_t'(0),      coord_t'(32767),  1'b0, 16'h0000},
    '{coord_t'(0),      coord_t'(-32768), 1'b0, 16'h0000},
    '{coord_t'(32767),  coord_t'(32767),  1'b0, 16'h0000},
    '{coord_t'(-32768), coord_t'(-32768), 1'b0, 16'h0000},
    '{coord_t'(-32768), coord_t'(32767),  1'b0, 16'h0000},
    '{coord_t'(32767),  coord_t'(-32768), 1'b0, 16'h0000},
    '{coord_t'(-32768), coord_t'(1),      1'b0, 16'h0000},
    '{coord_t'(-1),     coord_t'(-1),     1'b0, 16'h0000},
    '{coord_t'(1),      coord_t'(-1),     1'b0, 16'h0000},
    '{coord_t'(-1),     coord_t'(1),      1'b0, 16'h0000},
    '{coord_t'(1),      coord_t'(1),      1'b0, 16'h0000},
    '{coord_t'(21845),  coord_t'(-21846), 1'b0, 16'h0000},
    '{coord_t'(-21846), coord_t'(21845),  1'b0, 16'h0000},
    '{coord_t'(3),      coord_t'(-2),     1'b0, 16'h0000},
    '{coord_t'(2),      coord_t'(1),      1'b0, 16'h0000}
  };

  cordic_atan2_16 dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .done    (done),
    .angle   (angle)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Fold to the first quadrant, rotate toward the x axis, then unfold the angle.
  function automatic ang_t point_angle(input coord_t xc, input coord_t yc);
    logic signed [31:0] xr, yr, xs, ys;
    ang_t acc;
    xr = 32'(xc);
    yr = 32'(yc);
    if (xc < 0) xr = -xr;
    if (yc < 0) yr = -yr;
    acc = '0;
    for (int i = 0; i < ITERATIONS; i++) begin
      // stop rotating once y lands exactly on zero
      if (yr != 0) begin
        xs = xr >>> i;
        ys = yr >>> i;
        if (yr >= 0) begin
          xr = xr + ys;
          yr = yr - xs;
          acc = acc + ARCTAN_STEP[i];
        end else begin
          xr = xr - ys;
          yr = yr + xs;
          acc = acc - ARCTAN_STEP[i];
        end
      end
    end
    acc = acc >> 1;
    if (xc < 0) acc = HALF_TURN - acc;
    if (yc < 0) acc = ang_t'(0) - acc;
    return acc;
  endfunction

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return coord_t'($urandom);
    if (r < 7) return coord_t'($urandom_range(0, 16) - 8);
    if (r < 9) begin
      case ($urandom_range(0, 4))
        0: return coord_t'(-32768);
        1: return coord_t'(-1);
        2: return coord_t'(0);
        3: return coord_t'(1);
        default: return coord_t'(32767);
      endcase
    end
    return coord_t'($urandom_range(0, 512) - 256);
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Present one word, hold it until taken, and queue its angle.
  task automatic send_point(input coord_t xc, input coord_t yc, input ang_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    x_coord <= xc;
    y_coord <= yc;
    do @(posedge clk); while (busy);
    angle_q.push_back(want);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (angle_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("%t: angle %h with no point outstanding", $realtime, angle);
      end else begin
        ang_t want;
        want = angle_q.pop_front();
        if (angle !== want) begin
          bad_count++;
          if (bad_count <= MAX_SHOWN)
            $display("%t: angle expected %h, got %h", $realtime, want, angle);
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (point_rows[k]) begin
      if (point_rows[k].typed)
        send_point(point_rows[k].x, point_rows[k].y, point_rows[k].angle);
      else
        send_point(point_rows[k].x, point_rows[k].y,
                   point_angle(point_rows[k].x, point_rows[k].y));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      coord_t xc, yc;
      // switch between back-to-back stretches and gapped traffic
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      xc = pick_coord();
      yc = pick_coord();
      send_point(xc, yc, point_angle(xc, yc));
    end
    start <= 1'b0;

    waited = 0;
    while (angle_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (ITERATIONS + 8) @(posedge clk);
    bad_count += angle_q.size();

    if (bad_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
